/* sv/dht_pkg.sv */
package dht_pkg;

  localparam int KEY_W  = 31;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam int ST_W   = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam logic [ST_W-1:0] ST_PLACED   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_OCCUPIED = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot_index;
    logic [KEY_W-1:0]  stored_key;
    logic [CNT_W-1:0]  probe_count;
  } out_item_t;

endpackage

/* sv/dht_ram.sv */
module dht_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/double_hash_table_insert_top.sv */
// channel   ports                       handshake
// input     start, busy, in_data        item taken when start && !busy
// result    out_valid, out_data         one-cycle strobe, always taken
//
// insert: key reduction on the shared multiplier for the home index and the step, then one slot
//   probe per cycle; probe_count gives the occupied slots passed
// insert with no free slot found: status full, probe count TABLE_SIZE
// read: result set in the S_READ state and then registered (registered key memory read)
// reset clears all valid bits at once; the key memory is not reset
// the result strobe cannot be stalled; busy drops in the cycle the result is shown
module double_hash_table_insert_top #(
  parameter int TABLE_SIZE   = 16,
  parameter int STEP_MODULUS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dht_pkg::in_item_t  in_data,
  output logic               out_valid,
  output dht_pkg::out_item_t out_data
);

  import dht_pkg::*;

  localparam int IW      = $clog2(TABLE_SIZE);
  localparam int CW      = $clog2(TABLE_SIZE + 1);
  localparam int MAXM    = (TABLE_SIZE > STEP_MODULUS) ? TABLE_SIZE : STEP_MODULUS;
  localparam int FOLD_SH = 16;
  localparam int YW      = KEY_W - FOLD_SH + $clog2(MAXM) + 1;
  localparam int RW      = YW + 2;
  localparam int PW      = YW + RW;
  // floor(y / m) = (y * r) >> s for every y below 2**YW
  localparam int T_S     = YW + $clog2(TABLE_SIZE);
  localparam int M_S     = YW + $clog2(STEP_MODULUS);
  localparam longint unsigned T_R =
    ((64'd1 << T_S) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam longint unsigned M_R =
    ((64'd1 << M_S) + 64'(STEP_MODULUS) - 64'd1) / 64'(STEP_MODULUS);
  // weight of the upper key half, 2**FOLD_SH mod m
  localparam int T_W     = (1 << FOLD_SH) % TABLE_SIZE;
  localparam int M_W     = (1 << FOLD_SH) % STEP_MODULUS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_QUOT,
    S_REM,
    S_PROBE,
    S_READ
  } state_t;

  typedef enum logic [1:0] {
    P_HOME,
    P_STEP,
    P_STEPRED
  } pass_t;

  state_t                state_r, state_nxt;
  pass_t                 pass_r, pass_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [YW-1:0]         y_r, y_nxt;
  logic [YW-1:0]         q_r, q_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         step_r, step_nxt;
  logic [CW-1:0]         i_r, i_nxt;
  logic [SLOT_W-1:0]     rd_slot_r, rd_slot_nxt;
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic [YW-1:0]    mul_a;
  logic [RW-1:0]    mul_b;
  logic [PW-1:0]    prod;
  logic [YW-1:0]    q_new;
  logic [YW-1:0]    rem_full;
  logic [IW:0]      idx_sum;
  logic [IW:0]      idx_wrap;
  logic [31:0]      in_slot_w;
  logic [31:0]      rd_slot_w;
  logic             rd_hit;
  logic             ram_we;
  logic [KEY_W-1:0] ram_rdata;

  // shared multiplier: key fold, reciprocal quotient, quotient times modulus
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_FOLD: begin
        mul_a = YW'(key_r[KEY_W-1:FOLD_SH]);
        mul_b = (pass_r == P_STEP) ? RW'(M_W) : RW'(T_W);
      end
      S_QUOT: begin
        mul_a = y_r;
        mul_b = (pass_r == P_STEP) ? RW'(M_R) : RW'(T_R);
      end
      S_REM: begin
        mul_a = q_r;
        mul_b = (pass_r == P_STEP) ? RW'(STEP_MODULUS) : RW'(TABLE_SIZE);
      end
      default: begin
      end
    endcase
    prod     = {{RW{1'b0}}, mul_a} * {{YW{1'b0}}, mul_b};
    q_new    = (pass_r == P_STEP) ? YW'(prod >> M_S) : YW'(prod >> T_S);
    rem_full = y_r - prod[YW-1:0];
  end

  always_comb begin
    idx_sum  = {1'b0, idx_r} + {1'b0, step_r};
    idx_wrap = (idx_sum >= (IW+1)'(TABLE_SIZE)) ? (idx_sum - (IW+1)'(TABLE_SIZE)) : idx_sum;
  end

  assign in_slot_w = 32'(in_data.slot);
  assign rd_slot_w = 32'(rd_slot_r);
  assign rd_hit    = (rd_slot_w < 32'(TABLE_SIZE)) && valid_r[rd_slot_w[IW-1:0]];

  dht_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_SIZE)
  ) u_keys (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(key_r),
    .raddr(in_slot_w[IW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    key_nxt       = key_r;
    y_nxt         = y_r;
    q_nxt         = q_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    i_nxt         = i_r;
    rd_slot_nxt   = rd_slot_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.req_type == REQ_READ) begin
            rd_slot_nxt = in_data.slot;
            state_nxt   = S_READ;
          end else begin
            key_nxt   = in_data.key;
            pass_nxt  = P_HOME;
            state_nxt = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        y_nxt     = prod[YW-1:0] + YW'(key_r[FOLD_SH-1:0]);
        state_nxt = S_QUOT;
      end
      S_QUOT: begin
        q_nxt     = q_new;
        state_nxt = S_REM;
      end
      S_REM: begin
        unique case (pass_r)
          P_HOME: begin
            idx_nxt   = rem_full[IW-1:0];
            pass_nxt  = P_STEP;
            state_nxt = S_FOLD;
          end
          P_STEP: begin
            y_nxt     = YW'(STEP_MODULUS) - rem_full;
            pass_nxt  = P_STEPRED;
            state_nxt = S_QUOT;
          end
          P_STEPRED: begin
            step_nxt  = rem_full[IW-1:0];
            i_nxt     = '0;
            state_nxt = S_PROBE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_PROBE: begin
        if (i_r == CW'(TABLE_SIZE)) begin
          out_nxt.status      = ST_FULL;
          out_nxt.slot_index  = '0;
          out_nxt.stored_key  = '0;
          out_nxt.probe_count = CNT_W'(TABLE_SIZE);
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else if (!valid_r[idx_r]) begin
          ram_we              = 1'b1;
          valid_nxt[idx_r]    = 1'b1;
          out_nxt.status      = ST_PLACED;
          out_nxt.slot_index  = SLOT_W'(idx_r);
          out_nxt.stored_key  = key_r;
          out_nxt.probe_count = CNT_W'(i_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          idx_nxt = idx_wrap[IW-1:0];
          i_nxt   = i_r + 1'b1;
        end
      end
      S_READ: begin
        out_nxt.status      = rd_hit ? ST_OCCUPIED : ST_EMPTY;
        out_nxt.slot_index  = rd_slot_r;
        out_nxt.stored_key  = rd_hit ? ram_rdata : '0;
        out_nxt.probe_count = '0;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pass_r    <= pass_nxt;
    key_r     <= key_nxt;
    y_r       <= y_nxt;
    q_r       <= q_nxt;
    idx_r     <= idx_nxt;
    step_r    <= step_nxt;
    i_r       <= i_nxt;
    rd_slot_r <= rd_slot_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/dht_check.sv */
module dht_check (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input dht_pkg::in_item_t  in_data,
  input logic               out_valid,
  input dht_pkg::out_item_t out_data
);

  import dht_pkg::*;

  // one result per item, never two strobes in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was taken");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // read results follow accept after the registered read, echo the slot and carry a zero probe count
  a_read_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.req_type == REQ_READ) |=> ##1
      (out_valid && out_data.slot_index == $past(in_data.slot, 2)
       && out_data.probe_count == '0))
    else $error("read result missing or slot mismatch");

endmodule

bind double_hash_table_insert_top dht_check u_dht_check (.*);
